### hdl/cpd_pkg.sv
// Shared types, constants and pattern transforms for the character pattern dictionary.
// No dependencies; used by cpd_cell and char_pattern_dedup_with_transforms.
`default_nettype none
package cpd_pkg;

	localparam int PAT_W     = 64;
	localparam int PERM_W    = 4;
	localparam int MAX_IDX_W = 12;
	localparam int PERM_LAST = 15;

	localparam logic [1:0] REG_MIRROR_X = 2'd0;
	localparam logic [1:0] REG_MIRROR_Y = 2'd1;
	localparam logic [1:0] REG_ROTATE   = 2'd2;
	localparam logic [1:0] REG_INVERT   = 2'd3;

	typedef struct packed {
		logic                 valid;
		logic                 live;
		logic                 hit;
		logic [PERM_W-1:0]    perm;
		logic [MAX_IDX_W-1:0] idx;
		logic [PAT_W-1:0]     cand;
	} tok_t;

	function automatic logic [PAT_W-1:0] undo_rotation(input logic [PAT_W-1:0] v);
		logic [PAT_W-1:0] r;
		r = '0;
		for (int row = 0; row < 8; row++) begin
			for (int col = 0; col < 8; col++) begin
				r[((col ^ 7) << 3) | row] = v[(row << 3) | col];
			end
		end
		return r;
	endfunction

	function automatic logic [PAT_W-1:0] mirror_columns(input logic [PAT_W-1:0] v);
		logic [PAT_W-1:0] r;
		for (int y = 0; y < 8; y++) begin
			for (int b = 0; b < 8; b++) begin
				r[8*y + b] = v[8*y + 7 - b];
			end
		end
		return r;
	endfunction

	function automatic logic [PAT_W-1:0] mirror_rows(input logic [PAT_W-1:0] v);
		logic [PAT_W-1:0] r;
		for (int y = 0; y < 8; y++) begin
			r[8*y +: 8] = v[8*(7-y) +: 8];
		end
		return r;
	endfunction

	function automatic logic [PAT_W-1:0] apply_perm(input logic [PAT_W-1:0] v,
		input logic [PERM_W-1:0] p);
		logic [PAT_W-1:0] r;
		r = v;
		if (p[3]) r = undo_rotation(r);
		if (p[1]) r = mirror_columns(r);
		if (p[2]) r = mirror_rows(r);
		if (p[0]) r = ~r;
		return r;
	endfunction

endpackage
`default_nettype wire

### hdl/cpd_cell.sv
// One dictionary cell: holds one stored pattern and compares the passing item token.
// Depends on cpd_pkg for the token type.
`default_nettype none
module cpd_cell #(
	parameter int CELL_IDX = 0,
	parameter int CNT_W    = 9
) (
	input  wire                  clk,
	input  wire                  arst_n,
	input  cpd_pkg::tok_t        tok_i,
	output cpd_pkg::tok_t        tok_o,
	input  wire [CNT_W-1:0]      count,
	input  wire                  wr_en,
	input  wire [CNT_W-1:0]      wr_idx,
	input  wire [63:0]           wr_data
);
	import cpd_pkg::*;

	logic [PAT_W-1:0] entry_q;
	logic             valid_q;
	tok_t             tok_q;
	tok_t             tok_d;
	logic             hit_here;

	assign hit_here = tok_i.valid && tok_i.live && !tok_i.hit
		&& (CNT_W'(CELL_IDX) < count) && (entry_q == tok_i.cand);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			entry_q <= '0;
		end else if (wr_en && wr_idx == CNT_W'(CELL_IDX)) begin
			entry_q <= wr_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else begin
			valid_q <= tok_i.valid;
		end
	end

	always_comb begin
		tok_d = tok_i;
		if (hit_here) begin
			tok_d.hit = 1'b1;
			tok_d.idx = MAX_IDX_W'(CELL_IDX);
		end
	end

	always_ff @(posedge clk) begin
		tok_q <= tok_d;
	end

	always_comb begin
		tok_o       = tok_q;
		tok_o.valid = valid_q;
	end

endmodule
`default_nettype wire

### hdl/char_pattern_dedup_with_transforms.sv
// Top level of the character pattern dictionary: APB registers, sequencer and cell row.
// Depends on cpd_pkg and cpd_cell.
`default_nettype none
// An 8x8 pattern item is looked up against every stored entry under each of the sixteen
// permutations that the registers allow; the permutation tokens enter a row of TABLE_DEPTH
// cells one per cycle and move one cell per cycle, and a match item's result is loaded after
// the last token has left the row. The next item can be taken as soon as that result is
// loaded, and a clear item goes straight to loading its result. One item is worked on at a
// time; a new item is taken while a result waits, and its own result is held back until the
// waiting one has been taken.
module char_pattern_dedup_with_transforms #(
	parameter int TABLE_DEPTH = 256
) (
	input  wire        clk,
	input  wire        arst_n,
	input  wire        in_valid,
	output logic       in_ready,
	input  wire        opcode,
	input  wire [63:0] pattern_bits,
	output logic       out_valid,
	input  wire        out_ready,
	output logic [7:0] entry_index,
	output logic       used_invert,
	output logic       used_mirror_x,
	output logic       used_mirror_y,
	output logic       used_rotate,
	output logic       was_inserted,
	output logic       table_full,
	output logic [8:0] entries_used,
	input  wire        psel,
	input  wire        penable,
	input  wire        pwrite,
	input  wire [3:0]  paddr,
	input  wire [31:0] pwdata,
	output logic [31:0] prdata,
	output logic       pready
);
	import cpd_pkg::*;

	localparam int IW = $clog2(TABLE_DEPTH);
	localparam int CW = $clog2(TABLE_DEPTH + 1);

	localparam logic [1:0] ST_IDLE  = 2'd0;
	localparam logic [1:0] ST_INJ   = 2'd1;
	localparam logic [1:0] ST_DRAIN = 2'd2;
	localparam logic [1:0] ST_DONE  = 2'd3;

	logic [1:0]        state_q;
	logic [PERM_W-1:0] perm_q;
	logic [PERM_W-1:0] arr_q;
	logic              found_q;
	logic [PERM_W-1:0] hit_perm_q;
	logic [IW-1:0]     hit_idx_q;
	logic              op_q;
	logic [63:0]       pat_q;
	logic [CW-1:0]     count_q;
	logic              mx_q, my_q, rot_q, inv_q;

	tok_t              chain [0:TABLE_DEPTH];
	logic              perm_ok;
	logic              wr_en;
	logic [CW-1:0]     wr_idx;
	logic [63:0]       wr_data;
	logic              load_out;
	logic              cfg_wr;

	assign pready   = 1'b1;
	assign in_ready = (state_q == ST_IDLE);
	assign cfg_wr   = psel && penable && pwrite;
	assign load_out = (state_q == ST_DONE) && (!out_valid || out_ready);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mx_q  <= 1'b0;
			my_q  <= 1'b0;
			rot_q <= 1'b0;
			inv_q <= 1'b1;
		end else if (cfg_wr) begin
			unique case (paddr[3:2])
				REG_MIRROR_X: mx_q  <= pwdata[0];
				REG_MIRROR_Y: my_q  <= pwdata[0];
				REG_ROTATE:   rot_q <= pwdata[0];
				REG_INVERT:   inv_q <= pwdata[0];
				default:      ;
			endcase
		end
	end

	always_comb begin
		prdata = '0;
		unique case (paddr[3:2])
			REG_MIRROR_X: prdata[0] = mx_q;
			REG_MIRROR_Y: prdata[0] = my_q;
			REG_ROTATE:   prdata[0] = rot_q;
			REG_INVERT:   prdata[0] = inv_q;
			default:      prdata[0] = 1'b0;
		endcase
	end

	assign perm_ok = !(perm_q[0] && !inv_q) && !(perm_q[1] && !mx_q)
		&& !(perm_q[2] && !my_q) && !(perm_q[3] && !rot_q);

	always_comb begin
		chain[0].valid = (state_q == ST_INJ);
		chain[0].live  = perm_ok;
		chain[0].hit   = 1'b0;
		chain[0].perm  = perm_q;
		chain[0].idx   = '0;
		chain[0].cand  = apply_perm(pat_q, perm_q);
	end

	for (genvar i = 0; i < TABLE_DEPTH; i++) begin : g_cell
		cpd_cell #(
			.CELL_IDX (i),
			.CNT_W    (CW)
		) u_cell (
			.clk     (clk),
			.arst_n  (arst_n),
			.tok_i   (chain[i]),
			.tok_o   (chain[i+1]),
			.count   (count_q),
			.wr_en   (wr_en),
			.wr_idx  (wr_idx),
			.wr_data (wr_data)
		);
	end

	always_comb begin
		wr_en   = 1'b0;
		wr_idx  = count_q;
		wr_data = pat_q;
		if (load_out) begin
			if (op_q) begin
				wr_en   = 1'b1;
				wr_idx  = '0;
				wr_data = '0;
			end else if (!found_q && count_q < CW'(TABLE_DEPTH)) begin
				wr_en = 1'b1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			perm_q  <= '0;
			arr_q   <= '0;
			found_q <= 1'b0;
			count_q <= CW'(1);
		end else begin
			if (chain[TABLE_DEPTH].valid) begin
				arr_q <= arr_q + 1'b1;
				if (chain[TABLE_DEPTH].hit && !found_q) found_q <= 1'b1;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (in_valid) begin
						perm_q  <= '0;
						arr_q   <= '0;
						found_q <= 1'b0;
						state_q <= opcode ? ST_DONE : ST_INJ;
					end
				end
				ST_INJ: begin
					perm_q <= perm_q + 1'b1;
					if (perm_q == PERM_W'(PERM_LAST)) state_q <= ST_DRAIN;
				end
				ST_DRAIN: begin
					if (chain[TABLE_DEPTH].valid && arr_q == PERM_W'(PERM_LAST))
						state_q <= ST_DONE;
				end
				ST_DONE: begin
					if (load_out) begin
						state_q <= ST_IDLE;
						if (op_q) count_q <= CW'(1);
						else if (wr_en) count_q <= count_q + 1'b1;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			op_q  <= opcode;
			pat_q <= pattern_bits;
		end
		if (chain[TABLE_DEPTH].valid && chain[TABLE_DEPTH].hit && !found_q) begin
			hit_perm_q <= chain[TABLE_DEPTH].perm;
			hit_idx_q  <= chain[TABLE_DEPTH].idx[IW-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (load_out) begin
			out_valid <= 1'b1;
		end else if (out_ready) begin
			out_valid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load_out) begin
			if (op_q) begin
				entry_index   <= '0;
				used_invert   <= 1'b0;
				used_mirror_x <= 1'b0;
				used_mirror_y <= 1'b0;
				used_rotate   <= 1'b0;
				was_inserted  <= 1'b0;
				table_full    <= 1'b0;
				entries_used  <= 9'd1;
			end else if (found_q) begin
				entry_index   <= 8'(hit_idx_q);
				used_invert   <= hit_perm_q[0];
				used_mirror_x <= hit_perm_q[1];
				used_mirror_y <= hit_perm_q[2];
				used_rotate   <= hit_perm_q[3];
				was_inserted  <= 1'b0;
				table_full    <= 1'b0;
				entries_used  <= 9'(count_q);
			end else if (wr_en) begin
				entry_index   <= 8'(count_q);
				used_invert   <= 1'b0;
				used_mirror_x <= 1'b0;
				used_mirror_y <= 1'b0;
				used_rotate   <= 1'b0;
				was_inserted  <= 1'b1;
				table_full    <= 1'b0;
				entries_used  <= 9'(count_q + 1'b1);
			end else begin
				entry_index   <= '0;
				used_invert   <= 1'b0;
				used_mirror_x <= 1'b0;
				used_mirror_y <= 1'b0;
				used_rotate   <= 1'b0;
				was_inserted  <= 1'b0;
				table_full    <= 1'b1;
				entries_used  <= 9'(count_q);
			end
		end
	end

	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		count_q != '0 && count_q <= CW'(TABLE_DEPTH))
		else $error("entry count out of range");

	a_ins_full: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> !(was_inserted && table_full))
		else $error("insert and full flagged together");

	a_ins_flags: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && was_inserted |-> !(used_invert || used_mirror_x
			|| used_mirror_y || used_rotate))
		else $error("permutation flags on inserted item");

	a_ins_count: assert property (@(posedge clk) disable iff (!arst_n)
		load_out && !op_q && wr_en |=> count_q == $past(count_q) + 1'b1)
		else $error("count did not advance on insert");

	a_no_tok_idle: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_IDLE |-> !chain[TABLE_DEPTH].valid)
		else $error("token left the row while idle");

endmodule
`default_nettype wire
